/* rtl/cfc_pkg.sv */
// ---------------------------------------------------------------------------
// cfc_pkg
// Types, constants and the byte-wide crc-16 update shared by the frame checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] BYPASS_WORD_RESET = 16'h5555;
    localparam logic        BYPASS_EN_RESET   = 1'b1;

    // configuration register indexes
    localparam logic CFG_BYPASS_ENABLE = 1'b0;
    localparam logic CFG_BYPASS_WORD   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_BYPASS   = 2'd1,
        STATUS_MISMATCH = 2'd2,
        STATUS_SHORT    = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        frame_ok;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } verdict_t;

    // reflected crc-16, eight bit steps unrolled into one byte update
    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/cfc_frame_state.sv */
// ---------------------------------------------------------------------------
// cfc_frame_state
// Running crc, two-byte hold line and end-of-frame verdict logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfc_frame_state (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic              bypass_enable,
    input  wire logic [15:0]       bypass_word,
    output cfc_pkg::verdict_t      verdict
);
    import cfc_pkg::*;

    localparam logic [1:0] HOLD_FULL = 2'd2;

    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  held_older_reg, held_older_next;
    logic [7:0]  held_newer_reg, held_newer_next;
    logic [1:0]  held_count_reg, held_count_next;

    logic [15:0] crc_folded;
    logic [1:0]  count_inc;
    logic [15:0] trailing_word;

    // the older held byte leaves the hold line and enters the crc
    assign crc_folded = (held_count_reg == HOLD_FULL) ?
                        crc_fold_byte(crc_reg, held_older_reg) : crc_reg;
    assign count_inc  = (held_count_reg == HOLD_FULL) ?
                        HOLD_FULL : held_count_reg + 2'd1;
    assign trailing_word = {data_byte, held_newer_reg};

    always_comb
    begin
        verdict.computed_crc = crc_folded;
        if (count_inc != HOLD_FULL)
        begin
            verdict.status       = STATUS_SHORT;
            verdict.received_crc = 16'h0000;
        end
        else
        begin
            verdict.received_crc = trailing_word;
            if (bypass_enable && trailing_word == bypass_word)
                verdict.status = STATUS_BYPASS;
            else if (crc_folded == trailing_word)
                verdict.status = STATUS_MATCH;
            else
                verdict.status = STATUS_MISMATCH;
        end
        verdict.frame_ok = (verdict.status == STATUS_MATCH) ||
                           (verdict.status == STATUS_BYPASS);
    end

    always_comb
    begin
        crc_next        = crc_reg;
        held_older_next = held_older_reg;
        held_newer_next = held_newer_reg;
        held_count_next = held_count_reg;
        if (step)
        begin
            if (last_byte)
            begin
                crc_next        = CRC_INIT;
                held_older_next = 8'h00;
                held_newer_next = 8'h00;
                held_count_next = 2'd0;
            end
            else
            begin
                crc_next        = crc_folded;
                held_older_next = held_newer_reg;
                held_newer_next = data_byte;
                held_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            held_older_reg <= 8'h00;
            held_newer_reg <= 8'h00;
            held_count_reg <= 2'd0;
        end
        else
        begin
            crc_reg        <= crc_next;
            held_older_reg <= held_older_next;
            held_newer_reg <= held_newer_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/crc16_frame_checker.sv */
// ---------------------------------------------------------------------------
// crc16_frame_checker
// CRC-16 (0xA001 reflected, init 0xFFFF) check of byte frames, crc low byte first
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  in       | in_valid / in_stall      | data_byte, last_byte
//  out      | out_valid / out_stall    | status, frame_ok, computed_crc,
//           |                          | received_crc
//  cfg      | cfg_wr_en                | cfg_index, cfg_data
//
//  one item per cycle while in_stall is low; an accepted item is held in the input
//  register, and the verdict of a closing item is then registered in the output
//  register, where out_valid rises with it
//  in_stall rises only while the input register holds a closing item and the
//  output register is full and stalled
//  reset clears frame state and both valids and loads reset values into the config registers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             frame_ok,
    output logic [15:0]      computed_crc,
    output logic [15:0]      received_crc,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import cfc_pkg::*;

    logic        bypass_enable_reg;
    logic [15:0] bypass_word_reg;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic        out_valid_reg;
    verdict_t    verdict;
    verdict_t    result_reg;

    logic        out_free;
    logic        step;
    logic        in_take;

    assign out_free = !out_valid_reg || !out_stall;
    // a non-closing item never needs the output slot
    assign step     = in_valid_reg && (!last_reg || out_free);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    cfc_frame_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (byte_reg),
        .last_byte     (last_reg),
        .bypass_enable (bypass_enable_reg),
        .bypass_word   (bypass_word_reg),
        .verdict       (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_enable_reg <= BYPASS_EN_RESET;
            bypass_word_reg   <= BYPASS_WORD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BYPASS_ENABLE: bypass_enable_reg <= cfg_data[0];
                CFG_BYPASS_WORD:   bypass_word_reg   <= cfg_data;
                default:           bypass_word_reg   <= bypass_word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
            result_reg <= verdict;
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign frame_ok     = result_reg.frame_ok;
    assign computed_crc = result_reg.computed_crc;
    assign received_crc = result_reg.received_crc;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for crc16_frame_checker. Byte frames are streamed in
// and every verdict is checked against a cycle-free model of the checker.
// Directed frames come first, then random frames over several register
// settings and idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cfc_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 1950;
    localparam int PHASE_COUNT   = 8;

    // expected verdicts for the closed frames that have not yet been checked
    class frame_verdict_board;
        logic [15:0] crc_acc;
        logic [7:0]  held_old;
        logic [7:0]  held_new;
        int unsigned held_cnt;
        logic        bypass_on;
        logic [15:0] bypass_val;
        verdict_t    expected_verdicts[$];
        int unsigned errors;
        int unsigned status_seen[4];

        function new();
            bypass_on  = BYPASS_EN_RESET;
            bypass_val = BYPASS_WORD_RESET;
            errors     = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc_acc  = CRC_INIT;
            held_old = 8'h00;
            held_new = 8'h00;
            held_cnt = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
            logic [15:0] c;
            c = acc ^ {8'h00, b};
            repeat (8)
                c = (c >> 1) ^ (CRC_POLY & {16{c[0]}});
            return c;
        endfunction

        function void set_regs(logic en, logic [15:0] word);
            bypass_on  = en;
            bypass_val = word;
        endfunction

        function int unsigned outstanding();
            return expected_verdicts.size();
        endfunction

        // the two newest bytes stay in the hold line and never reach the crc
        function void note_byte(logic [7:0] b, logic closing);
            verdict_t    v;
            logic [15:0] rx;
            if (held_cnt >= 2)
                crc_acc = crc_step(crc_acc, held_old);
            held_old = held_new;
            held_new = b;
            if (held_cnt < 2)
                held_cnt++;
            if (!closing)
                return;
            v.computed_crc = crc_acc;
            if (held_cnt < 2)
            begin
                v.status       = STATUS_SHORT;
                v.received_crc = 16'h0000;
            end
            else
            begin
                rx = {held_new, held_old};
                v.received_crc = rx;
                if (bypass_on && rx == bypass_val)
                    v.status = STATUS_BYPASS;
                else if (rx == crc_acc)
                    v.status = STATUS_MATCH;
                else
                    v.status = STATUS_MISMATCH;
            end
            v.frame_ok = (v.status == STATUS_MATCH) || (v.status == STATUS_BYPASS);
            expected_verdicts.push_back(v);
            clear_frame();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_verdict(verdict_t got);
            verdict_t exp;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("verdict with none pending, status %0d", got.status));
                return;
            end
            exp = expected_verdicts.pop_front();
            status_seen[int'(exp.status)]++;
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.frame_ok !== exp.frame_ok)
                report($sformatf("frame_ok %0b, expected %0b", got.frame_ok, exp.frame_ok));
            if (got.computed_crc !== exp.computed_crc)
                report($sformatf("computed_crc %h, expected %h",
                                 got.computed_crc, exp.computed_crc));
            if (got.received_crc !== exp.received_crc)
                report($sformatf("received_crc %h, expected %h",
                                 got.received_crc, exp.received_crc));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        frame_ok;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_data;

    frame_verdict_board verdicts = new();

    logic [7:0]  frame_bytes[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned items_sent;
    int unsigned quiet_cycles;

    crc16_frame_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_ok     (frame_ok),
        .computed_crc (computed_crc),
        .received_crc (received_crc),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                verdicts.note_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
                verdicts.check_verdict({status_t'(status), frame_ok,
                                        computed_crc, received_crc});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [15:0] body_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = verdicts.crc_step(c, frame_bytes[i]);
        return c;
    endfunction

    task automatic add_word(input logic [15:0] w);
        frame_bytes.push_back(w[7:0]);
        frame_bytes.push_back(w[15:8]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic closing);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= closing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // wait until every verdict is in, then give the pipeline time to empty
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (verdicts.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(input logic en, input logic [15:0] word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BYPASS_ENABLE;
        cfg_data  <= {15'd0, en};
        @(posedge clk);
        cfg_index <= CFG_BYPASS_WORD;
        cfg_data  <= word;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        verdicts.set_regs(en, word);
    endtask

    task automatic random_frame();
        int          len;
        int          pick;
        logic [15:0] crc;
        pick = $urandom_range(99);
        if (pick < 5)
            len = 1;
        else if (pick < 12)
            len = 2;
        else if (pick < 95)
            len = $urandom_range(16, 3);
        else
            len = $urandom_range(64, 17);
        frame_bytes.delete();
        if (len == 1)
            frame_bytes.push_back(8'($urandom_range(255)));
        else
        begin
            repeat (len - 2)
                frame_bytes.push_back(8'($urandom_range(255)));
            crc  = body_crc();
            pick = $urandom_range(99);
            if (pick < 55)
                add_word(crc);
            else if (pick < 70)
                add_word(verdicts.bypass_val);
            else if (pick < 85)
                add_word(crc ^ (16'h0001 << $urandom_range(15)));
            else
                add_word(16'($urandom_range(65535)));
        end
        send_frame();
    endtask

    initial
    begin
        logic [15:0] word;
        logic        en;
        int unsigned phase_end;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_byte      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_BYPASS_ENABLE;
        cfg_data       = 16'h0000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bypass on, word 0x5555
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        frame_bytes.delete();
        add_word(16'hFFFF);             // empty body, crc of nothing matches
        send_frame();
        frame_bytes.delete();
        add_word(16'h5555);
        send_frame();
        frame_bytes.delete();
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h7F);
        add_word(body_crc());
        send_frame();
        frame_bytes[4] = frame_bytes[4] ^ 8'h01;
        send_frame();
        settle();

        // bypass word equal to a correct crc: bypass wins
        configure(1'b1, 16'hFFFF);
        frame_bytes.delete();
        add_word(16'hFFFF);
        send_frame();
        settle();

        // bypass off: trailer equal to the word is judged by crc alone
        configure(1'b0, 16'h0000);
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        add_word(16'h0000);
        send_frame();
        settle();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin en = 1'b1; word = BYPASS_WORD_RESET; end
                1: begin en = 1'b0; word = 16'h0000; end
                2: begin en = 1'b1; word = 16'hFFFF; end
                3: begin en = 1'b1; word = 16'($urandom_range(65535)); end
                4: begin en = 1'b0; word = 16'($urandom_range(65535)); end
                5: begin en = 1'b1; word = 16'h0000; end
                6: begin en = 1'b1; word = 16'($urandom_range(65535)); end
                default: begin en = 1'b0; word = 16'hFFFF; end
            endcase
            configure(en, word);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
                default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
            endcase
            phase_end = items_sent + ITEM_TARGET / PHASE_COUNT;
            while (items_sent < phase_end)
                random_frame();
            settle();
        end

        $display("sent %0d bytes over %0d register settings and four idle patterns",
                 items_sent, PHASE_COUNT + 3);
        $display("verdicts: match %0d, bypass %0d, mismatch %0d, too short %0d",
                 verdicts.status_seen[STATUS_MATCH], verdicts.status_seen[STATUS_BYPASS],
                 verdicts.status_seen[STATUS_MISMATCH], verdicts.status_seen[STATUS_SHORT]);
        if (verdicts.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/cfc_pkg.sv
rtl/cfc_frame_state.sv
rtl/crc16_frame_checker.sv
tb/tb.sv
